@@ sv/lste_pkg.sv @@
// Package for the line start table engine.
// Holds operation and status codes and the sequencer state type; no dependencies.
package lste_pkg;

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_RANGE      = 3'd2,
    OP_FIND_OFF   = 3'd3,
    OP_FIND_PIX   = 3'd4,
    OP_BUMP_OFF   = 3'd5,
    OP_BUMP_ORG   = 3'd6,
    OP_MAX_WIDTH  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_SRCH   = 11'b00000000010,
    S_SRCH_W = 11'b00000000100,
    S_SRCH_N = 11'b00000001000,
    S_MOVE   = 11'b00000010000,
    S_MOVE_W = 11'b00000100000,
    S_WALK   = 11'b00001000000,
    S_WALK_W = 11'b00010000000,
    S_DONE   = 11'b00100000000,
    S_SRCH2  = 11'b01000000000,
    S_FOUND  = 11'b10000000000
  } state_e;

  localparam int unsigned EntryW = 31 + 32 + 24;

endpackage

@@ sv/line_start_table_engine_unit.sv @@
// Line start table engine: one RAM holds offset, origin and width per line.
// Depends on lste_pkg and lste_ram.
//
// One operation at a time; busy is high from the accepting edge until the result
// strobe. Lookups use one RAM port: a bisection step that moves hi down passes
// S_SRCH and S_SRCH_W, one that also reads the next entry adds S_SRCH_N and
// S_SRCH2. Insert, remove and range removal move the tail one entry at a time
// through S_MOVE and S_MOVE_W, range removal adjusting the moved offsets on the
// way; bumps and range removals that drop nothing walk the entries from the start
// index, max width from entry 0, through S_WALK and S_WALK_W. The result is shown
// for one cycle on done_o and cannot be stalled. No clearing pass after reset.
module line_start_table_engine_unit #(
  parameter int unsigned MAX_LINES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [10:0] index_i,
  input  logic [10:0] count_i,
  input  logic [30:0] offset_i,
  input  logic [30:0] to_offset_i,
  input  logic signed [31:0] pixel_i,
  input  logic signed [31:0] delta_i,
  input  logic [30:0] line_offset_i,
  input  logic signed [31:0] line_origin_i,
  input  logic [23:0] line_width_i,
  output logic        done_o,
  output logic [9:0]  line_index_o,
  output logic [23:0] max_width_o,
  output logic [10:0] line_count_o,
  output logic [1:0]  status_o
);
  import lste_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LINES);
  localparam int unsigned CW = $clog2(MAX_LINES + 1);
  localparam int unsigned XW = ((CW > 11) ? CW : 11) + 1;

  state_e state_q;
  op_e    op_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] lo_q, hi_q, mid_q, ptr_q, end_q;
  logic [CW-1:0] a_q;
  logic          second_q;
  logic [30:0]   key_off_q, to_off_q, ins_off_q;
  logic signed [31:0] key_pix_q, delta_q, ins_org_q;
  logic [23:0]   ins_w_q;
  logic [23:0]   widest_q;
  logic [9:0]    found_q;
  logic [1:0]    status_q;
  logic [CW:0]   dist_q;

  logic              we;
  logic [AW-1:0]     addr;
  logic [EntryW-1:0] wdata, rdata;

  lste_ram #(.Width(EntryW), .Depth(MAX_LINES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  logic [30:0] r_off;
  logic signed [31:0] r_org;
  logic [23:0] r_w;
  assign r_off = rdata[EntryW-1 -: 31];
  assign r_org = rdata[55:24];
  assign r_w   = rdata[23:0];

  // Key of the probed word, widened so offsets and pixels share one compare.
  logic signed [32:0] key_q33, rkey33;
  assign key_q33 = (op_q == OP_FIND_PIX) ? {key_pix_q[31], key_pix_q}
                                        : {2'b00, key_off_q};
  assign rkey33  = (op_q == OP_FIND_PIX) ? {r_org[31], r_org} : {2'b00, r_off};

  logic signed [33:0] off_sum, org_sum;
  logic [30:0] off_sat;
  logic signed [31:0] org_sat;
  assign off_sum = {3'b000, r_off} + {{2{delta_q[31]}}, delta_q};
  assign org_sum = {{2{r_org[31]}}, r_org} + {{2{delta_q[31]}}, delta_q};
  always_comb begin
    if (off_sum < 0) off_sat = '0;
    else if (off_sum > 34'sh7FFFFFFF) off_sat = 31'h7FFFFFFF;
    else off_sat = off_sum[30:0];
    if (org_sum < -34'sh80000000) org_sat = 32'h80000000;
    else if (org_sum > 34'sh7FFFFFFF) org_sat = 32'h7FFFFFFF;
    else org_sat = org_sum[31:0];
  end

  logic [CW-1:0] mid_c;
  logic [CW:0]   lohi;
  assign lohi  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_c = lohi[CW:1];

  logic [CW:0] cnt_dec;
  assign cnt_dec = {1'b0, cnt_q} - {{CW{1'b0}}, 1'b1};

  // Range checks at a width that holds index plus count.
  logic [XW-1:0] idx_w, span_w, cnt_w;
  assign idx_w  = XW'(index_i);
  assign span_w = XW'(index_i) + XW'(count_i);
  assign cnt_w  = XW'(cnt_q);

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // Move direction: insert walks down from the top, removal walks up.
  logic move_up;
  assign move_up = (op_q != OP_INSERT);

  always_comb begin
    we      = 1'b0;
    addr    = ptr_q[AW-1:0];
    wdata   = rdata;
    case (state_q)
      S_SRCH:   addr = mid_c[AW-1:0];
      S_SRCH_N: addr = mid_q[AW-1:0] + AW'(1);
      S_MOVE: begin
        if (move_up) addr = AW'(ptr_q + dist_q[CW-1:0]);
        else         addr = AW'(ptr_q - CW'(1));
      end
      S_MOVE_W: begin
        we    = 1'b1;
        // Range removal shifts the offsets of the entries it moves.
        wdata = (op_q == OP_RANGE) ? {off_sat, r_org, r_w} : rdata;
      end
      S_WALK_W: begin
        we = (op_q != OP_MAX_WIDTH);
        if (op_q == OP_BUMP_ORG) wdata = {r_off, org_sat, r_w};
        else                     wdata = {off_sat, r_org, r_w};
      end
      S_DONE: begin
        we    = (op_q == OP_INSERT) && (status_q == ST_OK);
        wdata = {ins_off_q, ins_org_q, ins_w_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      done_o   <= 1'b0;
      second_q <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q      <= op_e'(kind_i);
            key_off_q <= offset_i;
            to_off_q  <= to_offset_i;
            key_pix_q <= pixel_i;
            delta_q   <= delta_i;
            ins_off_q <= line_offset_i;
            ins_org_q <= line_origin_i;
            ins_w_q   <= line_width_i;
            widest_q  <= '0;
            found_q   <= '0;
            status_q  <= ST_OK;
            second_q  <= 1'b0;
            lo_q      <= '0;
            hi_q      <= CW'(cnt_dec);
            mid_q     <= '0;
            dist_q    <= '0;
            state_q   <= S_DONE;
            case (op_e'(kind_i))
              OP_INSERT: begin
                if ({1'b0, cnt_q} >= (CW+1)'(MAX_LINES)) status_q <= ST_FULL;
                else if (idx_w > cnt_w) status_q <= ST_RANGE;
                else begin
                  ptr_q   <= cnt_q;
                  end_q   <= CW'(index_i);
                  state_q <= (cnt_q == CW'(index_i)) ? S_DONE : S_MOVE;
                end
              end
              OP_REMOVE: begin
                if (idx_w > cnt_w || span_w > cnt_w) status_q <= ST_RANGE;
                else begin
                  ptr_q  <= CW'(index_i);
                  dist_q <= (CW+1)'(count_i);
                  end_q  <= CW'(cnt_q - CW'(count_i));
                  if (count_i == '0 || span_w == cnt_w) begin
                    cnt_q   <= CW'(cnt_q - CW'(count_i));
                    state_q <= S_DONE;
                  end else state_q <= S_MOVE;
                end
              end
              OP_RANGE, OP_FIND_OFF, OP_FIND_PIX: begin
                state_q <= (cnt_q > CW'(1)) ? S_SRCH : S_FOUND;
              end
              OP_BUMP_OFF, OP_BUMP_ORG: begin
                if (idx_w > cnt_w) status_q <= ST_RANGE;
                else begin
                  ptr_q   <= CW'(index_i);
                  state_q <= (CW'(index_i) == cnt_q) ? S_DONE : S_WALK;
                end
              end
              default: begin
                ptr_q   <= '0;
                state_q <= (cnt_q == '0) ? S_DONE : S_WALK;
              end
            endcase
          end
        end
        S_SRCH: begin
          mid_q   <= mid_c;
          state_q <= S_SRCH_W;
        end
        S_SRCH_W: begin
          if (key_q33 >= rkey33) state_q <= S_SRCH_N;
          else begin
            hi_q    <= mid_q;
            state_q <= (lo_q < mid_q) ? S_SRCH : S_FOUND;
          end
        end
        S_SRCH_N: state_q <= S_SRCH2;
        S_SRCH2: begin
          // Next entry is in: stop below it, else move lo past mid.
          if (key_q33 < rkey33) state_q <= S_FOUND;
          else begin
            lo_q    <= mid_q + CW'(1);
            state_q <= (mid_q + CW'(1) < hi_q) ? S_SRCH : S_FOUND;
          end
        end
        S_FOUND: begin
          // Search result is mid.
          if (op_q == OP_RANGE) begin
            if (!second_q) begin
              a_q       <= mid_q;
              second_q  <= 1'b1;
              delta_q   <= $signed({1'b0, key_off_q}) - $signed({1'b0, to_off_q});
              key_off_q <= to_off_q;
              lo_q      <= '0;
              hi_q      <= CW'(cnt_dec);
              mid_q     <= '0;
              state_q   <= (cnt_q > CW'(1)) ? S_SRCH : S_FOUND;
            end else begin
              if (mid_q > a_q) begin
                ptr_q   <= a_q + CW'(1);
                dist_q  <= (CW+1)'(mid_q - a_q);
                end_q   <= cnt_q - (mid_q - a_q);
                if (mid_q == cnt_q - CW'(1)) begin
                  // Nothing follows the end line: drop the tail outright.
                  cnt_q   <= a_q + CW'(1);
                  state_q <= S_DONE;
                end else state_q <= S_MOVE;
              end else begin
                ptr_q   <= a_q + CW'(1);
                state_q <= (a_q + CW'(1) >= cnt_q) ? S_DONE : S_WALK;
              end
            end
          end else begin
            found_q <= 10'(mid_q);
            state_q <= S_DONE;
          end
        end
        S_MOVE: state_q <= S_MOVE_W;
        S_MOVE_W: begin
          if (move_up) begin
            if (ptr_q + CW'(1) == end_q) begin
              cnt_q   <= end_q;
              state_q <= S_DONE;
            end else begin
              ptr_q   <= ptr_q + CW'(1);
              state_q <= S_MOVE;
            end
          end else begin
            ptr_q   <= ptr_q - CW'(1);
            state_q <= (ptr_q - CW'(1) == end_q) ? S_DONE : S_MOVE;
          end
        end
        S_WALK: state_q <= S_WALK_W;
        S_WALK_W: begin
          if (r_w > widest_q) widest_q <= r_w;
          ptr_q   <= ptr_q + CW'(1);
          state_q <= (ptr_q + CW'(1) >= cnt_q) ? S_DONE : S_WALK;
        end
        S_DONE: begin
          if (op_q == OP_INSERT && status_q == ST_OK) cnt_q <= cnt_q + CW'(1);
          done_o       <= 1'b1;
          line_index_o <= found_q;
          max_width_o  <= (op_q == OP_MAX_WIDTH) ? widest_q : '0;
          line_count_o <= 11'(
            (op_q == OP_INSERT && status_q == ST_OK) ? cnt_q + CW'(1) : cnt_q);
          status_o     <= status_q;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} <= (CW+1)'(MAX_LINES)) else $error("line count over capacity");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("strobe while busy");
`endif

endmodule

@@ sv/lste_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module lste_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
